// ===== hw/rtl/cpst_pkg.sv =====
package cpst_pkg;

  // Table geometry.
  localparam int ROWS  = 1024;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Rows as a signed value in the width of a y difference.
  localparam logic signed [16:0] ROWS_S = 17'(ROWS);

  // Width of the signed 18.16 x accumulator and of the slope.
  localparam int XW = 34;

  // Restoring divider: one quotient bit per cycle.
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Empty row markers.
  localparam logic signed [15:0] EMPTY_LEFT  = 16'sh7fff;
  localparam logic signed [15:0] EMPTY_RIGHT = 16'sh8000;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  // One table row.
  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } span_t;

  // Table write port.
  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] addr;
    span_t            data;
  } wr_t;

  // Table read port.
  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] addr;
  } rd_t;

  // Divider start request: magnitude of the numerator, divisor and sign.
  typedef struct packed {
    logic        start;
    logic [31:0] num_mag;
    logic [15:0] den;
    logic        neg;
  } div_req_t;

  // Saturate an 18-bit signed integer to 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/cpst_intf.sv =====
// Request channel: one operation per transfer.
interface cpst_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [15:0] first_x;
  logic signed [15:0] first_y;
  logic signed [15:0] second_x;
  logic signed [15:0] second_y;
  logic [9:0]         row_index;

  modport source (
    output valid, opcode, first_x, first_y, second_x, second_y, row_index,
    input  ready
  );
  modport sink (
    input  valid, opcode, first_x, first_y, second_x, second_y, row_index,
    output ready
  );
endinterface

// Response channel: one result per request.
interface cpst_out_if;
  logic               valid;
  logic               ready;
  logic [9:0]         span_row;
  logic signed [15:0] span_left;
  logic signed [15:0] span_right;
  logic               span_fill;

  modport source (
    output valid, span_row, span_left, span_right, span_fill,
    input  ready
  );
  modport sink (
    input  valid, span_row, span_left, span_right, span_fill,
    output ready
  );
endinterface

// ===== hw/rtl/cpst_div.sv =====
// Sequential restoring divider for the edge slope.
// The quotient magnitude is truncated, which with the sign applied afterward
// gives truncation toward zero.
module cpst_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cpst_pkg::div_req_t            req_i,
  output logic                          done_o,
  output logic signed [cpst_pkg::XW-1:0] quo_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [cpst_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]                    rem_q, rem_d;
  logic [31:0]                    quo_q, quo_d;
  logic [15:0]                    den_q, den_d;
  logic                           neg_q, neg_d;
  logic [16:0]                    rem_sh;
  logic                           fits;
  logic [16:0]                    rem_sub;
  logic signed [cpst_pkg::XW-1:0] mag;

  // One trial subtraction per cycle.
  always_comb begin
    rem_sh  = {rem_q, quo_q[31]};
    fits    = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.num_mag;
      den_d  = req_i.den;
      neg_d  = req_i.neg;
    end else if (busy_q) begin
      quo_d = {quo_q[30:0], fits};
      rem_d = fits ? rem_sub[15:0] : rem_sh[15:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == cpst_pkg::DIV_CNT_W'(cpst_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // Apply the sign to the finished magnitude.
  assign mag    = $signed({2'b00, quo_q});
  assign quo_o  = neg_q ? -mag : mag;
  assign done_o = done_q;

endmodule

// ===== hw/rtl/cpst_table.sv =====
// Span table storage: one write and one read per cycle, registered read data.
module cpst_table (
  input  logic               clk_i,
  input  cpst_pkg::wr_t      wr_i,
  input  cpst_pkg::rd_t      rd_i,
  output cpst_pkg::span_t    rdata_o
);

  cpst_pkg::span_t mem_q [cpst_pkg::ROWS];
  cpst_pkg::span_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Read port; the read data is registered.
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/convex_polygon_span_table.sv =====
// Per-row span table for convex polygon fill, held in one synchronous memory of
// ROWS words, each word a signed 16-bit left and right edge. After reset the
// block sweeps the memory to mark every row empty and accepts no request
// meanwhile. Clear also sweeps the memory, one row per cycle, then answers
// through the response register. Read row does one memory read and then fills
// the response register. Add edge computes its slope with a one-bit-per-cycle
// divider, positions x on the first row inside the table with one multiply,
// then walks the covered rows one per cycle with a read-modify-write of the
// memory; a horizontal edge, or one that covers no row of the table, answers at
// once. Every request returns exactly one result; the result register lets the
// next request be taken while a result still waits.
module convex_polygon_span_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  cpst_in_if.sink     req_i,
  cpst_out_if.source  rsp_o
);

  localparam int RW = cpst_pkg::ROW_W;
  localparam int XW = cpst_pkg::XW;

  // Control states.
  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_RDAT  = 4'd2;
  localparam logic [3:0] ST_DIV   = 4'd3;
  localparam logic [3:0] ST_MUL   = 4'd4;
  localparam logic [3:0] ST_XINIT = 4'd5;
  localparam logic [3:0] ST_WALK  = 4'd6;
  localparam logic [3:0] ST_DRAIN = 4'd7;
  localparam logic [3:0] ST_RESP  = 4'd8;

  logic [3:0]            state_q, state_d;
  logic [RW-1:0]         ptr_q, ptr_d;
  logic [RW-1:0]         last_q, last_d;
  logic                  pend_q, pend_d;
  logic                  oob_q, oob_d;
  logic signed [15:0]    xa_q, xa_d;
  logic [16:0]           skip_q, skip_d;
  logic signed [XW-1:0]  slope_q, slope_d;
  logic signed [XW-1:0]  prod_q, prod_d;
  logic signed [XW-1:0]  x_q, x_d;

  // Update stage, registered in step with the table read data.
  logic                  pv_q, pv_d;
  logic [RW-1:0]         pa_q, pa_d;
  logic signed [XW-1:0]  px_q, px_d;

  // Pending result and response register.
  logic [9:0]            res_row_q, res_row_d;
  logic signed [15:0]    res_left_q, res_left_d;
  logic signed [15:0]    res_right_q, res_right_d;
  logic                  res_fill_q, res_fill_d;
  logic                  rsp_valid_q, rsp_valid_d;
  logic [9:0]            rsp_row_q, rsp_row_d;
  logic signed [15:0]    rsp_left_q, rsp_left_d;
  logic signed [15:0]    rsp_right_q, rsp_right_d;
  logic                  rsp_fill_q, rsp_fill_d;

  cpst_pkg::wr_t         wr;
  cpst_pkg::rd_t         rd;
  cpst_pkg::span_t       rdata;
  cpst_pkg::span_t       upd;
  cpst_pkg::div_req_t    div_req;
  logic                  div_done;
  logic signed [XW-1:0]  div_quo;

  // Edge setup signals.
  logic                  accept;
  logic                  swap;
  logic signed [15:0]    ya, yb, xa, xb;
  logic signed [16:0]    dx, ys, ye, ya_w, yb_w;
  logic [15:0]           dx_mag;
  logic signed [16:0]    dx_neg;
  logic signed [16:0]    ye_m1;
  logic                  covers;
  logic signed [XW+17:0] mul_full;
  logic signed [XW-1:0]  lx, rx;
  logic signed [XW-1:0]  ceil_x;
  cpst_pkg::span_t       empty_span;
  cpst_pkg::span_t       rd_span;

  assign empty_span = '{left: cpst_pkg::EMPTY_LEFT, right: cpst_pkg::EMPTY_RIGHT};
  assign accept     = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);

  // Order the endpoints by y and find the rows of the table that are covered.
  always_comb begin
    swap   = req_i.first_y > req_i.second_y;
    ya     = swap ? req_i.second_y : req_i.first_y;
    yb     = swap ? req_i.first_y  : req_i.second_y;
    xa     = swap ? req_i.second_x : req_i.first_x;
    xb     = swap ? req_i.first_x  : req_i.second_x;
    ya_w   = {ya[15], ya};
    yb_w   = {yb[15], yb};
    dx     = {xb[15], xb} - {xa[15], xa};
    dx_neg = -dx;
    dx_mag = dx[16] ? dx_neg[15:0] : dx[15:0];
    ys     = ya[15] ? 17'sd0 : ya_w;
    ye     = (yb_w > cpst_pkg::ROWS_S) ? cpst_pkg::ROWS_S : yb_w;
    ye_m1  = ye - 17'sd1;
    covers = ys < ye;
  end

  // Divider start, issued with an accepted add-edge request that is not horizontal and covers a row.
  always_comb begin
    div_req.start   = accept && (cpst_pkg::op_e'(req_i.opcode) == cpst_pkg::OP_ADD)
                      && (req_i.first_y != req_i.second_y) && covers;
    div_req.num_mag = {dx_mag, 16'h0000};
    div_req.den     = 16'(yb_w - ya_w);
    div_req.neg     = dx[16];
  end

  cpst_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Skip rows above the table in one step.
  assign mul_full = slope_q * $signed({1'b0, skip_q});

  // Widen one row from the value read back from the table.
  always_comb begin
    lx     = $signed({{2{rdata.left[15]}}, rdata.left, 16'h0000});
    rx     = $signed({{2{rdata.right[15]}}, rdata.right, 16'h0000});
    ceil_x = px_q + XW'(65535);
    upd    = rdata;
    if (px_q < lx) begin
      upd.left = cpst_pkg::sat16(ceil_x[XW-1:16]);
    end
    if (px_q > rx) begin
      upd.right = cpst_pkg::sat16(px_q[XW-1:16]);
    end
  end

  // Table ports: the clearing sweep owns the write port while it runs.
  always_comb begin
    if (state_q == ST_CLEAR) begin
      wr.en   = 1'b1;
      wr.addr = ptr_q;
      wr.data = empty_span;
    end else begin
      wr.en   = pv_q;
      wr.addr = pa_q;
      wr.data = upd;
    end
    rd.en   = 1'b0;
    rd.addr = ptr_q;
    if (state_q == ST_WALK) begin
      rd.en = 1'b1;
    end else if (accept && (cpst_pkg::op_e'(req_i.opcode) == cpst_pkg::OP_READ)) begin
      rd.en   = 1'b1;
      rd.addr = RW'(req_i.row_index);
    end
  end

  cpst_table u_table (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .rd_i    (rd),
    .rdata_o (rdata)
  );

  assign rd_span = oob_q ? empty_span : rdata;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    last_d      = last_q;
    pend_d      = pend_q;
    oob_d       = oob_q;
    xa_d        = xa_q;
    skip_d      = skip_q;
    slope_d     = slope_q;
    prod_d      = prod_q;
    x_d         = x_q;
    pv_d        = 1'b0;
    pa_d        = pa_q;
    px_d        = px_q;
    res_row_d   = res_row_q;
    res_left_d  = res_left_q;
    res_right_d = res_right_q;
    res_fill_d  = res_fill_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_row_d   = rsp_row_q;
    rsp_left_d  = rsp_left_q;
    rsp_right_d = rsp_right_q;
    rsp_fill_d  = rsp_fill_q;

    unique case (state_q)
      ST_CLEAR: begin
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == RW'(cpst_pkg::ROWS - 1)) begin
          state_d = pend_q ? ST_RESP : ST_IDLE;
          pend_d  = 1'b0;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          res_row_d   = '0;
          res_left_d  = '0;
          res_right_d = '0;
          res_fill_d  = 1'b0;
          unique case (cpst_pkg::op_e'(req_i.opcode))
            cpst_pkg::OP_CLEAR: begin
              ptr_d   = '0;
              pend_d  = 1'b1;
              state_d = ST_CLEAR;
            end
            cpst_pkg::OP_ADD: begin
              xa_d    = xa;
              skip_d  = ya[15] ? 17'(-ya_w) : 17'd0;
              ptr_d   = RW'(ys);
              last_d  = RW'(ye_m1);
              state_d = div_req.start ? ST_DIV : ST_RESP;
            end
            cpst_pkg::OP_READ: begin
              res_row_d = req_i.row_index;
              oob_d     = int'(req_i.row_index) >= cpst_pkg::ROWS;
              state_d   = ST_RDAT;
            end
            cpst_pkg::OP_NOP: begin
              state_d = ST_RESP;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_RDAT: begin
        res_left_d  = rd_span.left;
        res_right_d = rd_span.right;
        res_fill_d  = rd_span.left < rd_span.right;
        state_d     = ST_RESP;
      end

      ST_DIV: begin
        if (div_done) begin
          slope_d = div_quo;
          state_d = ST_MUL;
        end
      end

      ST_MUL: begin
        prod_d  = mul_full[XW-1:0];
        state_d = ST_XINIT;
      end

      ST_XINIT: begin
        x_d     = $signed({{2{xa_q[15]}}, xa_q, 16'h0000}) + prod_q;
        state_d = ST_WALK;
      end

      ST_WALK: begin
        pv_d  = 1'b1;
        pa_d  = ptr_q;
        px_d  = x_q;
        x_d   = x_q + slope_q;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == last_q) begin
          state_d = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_row_d   = res_row_q;
          rsp_left_d  = res_left_q;
          rsp_right_d = res_right_q;
          rsp_fill_d  = res_fill_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      pv_q        <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      pv_q        <= pv_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    last_q      <= last_d;
    oob_q       <= oob_d;
    xa_q        <= xa_d;
    skip_q      <= skip_d;
    slope_q     <= slope_d;
    prod_q      <= prod_d;
    x_q         <= x_d;
    pa_q        <= pa_d;
    px_q        <= px_d;
    res_row_q   <= res_row_d;
    res_left_q  <= res_left_d;
    res_right_q <= res_right_d;
    res_fill_q  <= res_fill_d;
    rsp_row_q   <= rsp_row_d;
    rsp_left_q  <= rsp_left_d;
    rsp_right_q <= rsp_right_d;
    rsp_fill_q  <= rsp_fill_d;
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.span_row   = rsp_row_q;
  assign rsp_o.span_left  = rsp_left_q;
  assign rsp_o.span_right = rsp_right_q;
  assign rsp_o.span_fill  = rsp_fill_q;

endmodule

// ===== test/span_checker.sv =====
// Watches both channels of the span table, keeps its own copy of the row
// spans, and compares every response transfer with the oldest predicted span.
module span_checker (
  input  logic   clk_i,
  input  logic   rst_ni,
  cpst_in_if     req,
  cpst_out_if    rsp,
  output int     fail_count,
  output int     pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [9:0]         row;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               fill;
  } span_result_t;

  // Shadow copy of the table.
  logic signed [15:0] left_tbl  [cpst_pkg::ROWS];
  logic signed [15:0] right_tbl [cpst_pkg::ROWS];

  // Spans predicted for requests whose response has not arrived yet.
  span_result_t pending_spans [$];

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > 32767) begin
      return 16'sh7fff;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic void clear_spans();
    for (int i = 0; i < cpst_pkg::ROWS; i++) begin
      left_tbl[i]  = cpst_pkg::EMPTY_LEFT;
      right_tbl[i] = cpst_pkg::EMPTY_RIGHT;
    end
  endfunction

  // Walk one edge from its upper to its lower endpoint and widen the rows it
  // crosses. Rows outside the table are skipped, but x is still positioned
  // as if it had stepped across them.
  function automatic void trace_edge(input longint ax, input longint ay,
                                     input longint bx, input longint by);
    longint slope;
    longint x;
    longint t;
    longint y_lo;
    longint y_hi;
    if (ay == by) begin
      return;
    end
    if (ay > by) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    slope = ((bx - ax) * 65536) / (by - ay);
    y_lo  = (ay < 0) ? 0 : ay;
    y_hi  = (by > cpst_pkg::ROWS) ? cpst_pkg::ROWS : by;
    for (longint y = y_lo; y < y_hi; y++) begin
      x = ax * 65536 + slope * (y - ay);
      if (x < longint'(left_tbl[y]) * 65536) begin
        left_tbl[y] = clip16(-((-x) >>> 16));
      end
      if (x > longint'(right_tbl[y]) * 65536) begin
        right_tbl[y] = clip16(x >>> 16);
      end
    end
  endfunction

  // Apply one request to the shadow table and return the span it answers.
  function automatic span_result_t predict_span(input cpst_pkg::op_e op,
                                                input longint ax, input longint ay,
                                                input longint bx, input longint by,
                                                input logic [9:0] row);
    span_result_t       res;
    logic signed [15:0] l;
    logic signed [15:0] r;
    res = '0;
    case (op)
      cpst_pkg::OP_CLEAR: begin
        clear_spans();
      end
      cpst_pkg::OP_ADD: begin
        trace_edge(ax, ay, bx, by);
      end
      cpst_pkg::OP_READ: begin
        l = cpst_pkg::EMPTY_LEFT;
        r = cpst_pkg::EMPTY_RIGHT;
        if (row < cpst_pkg::ROWS) begin
          l = left_tbl[row];
          r = right_tbl[row];
        end
        res.row   = row;
        res.left  = l;
        res.right = r;
        res.fill  = (l < r);
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  initial begin
    fail_count    = 0;
    pending_count = 0;
    clear_spans();
  end

  // Responses are matched first, since a request taken at this edge cannot
  // be answered at the same edge.
  always @(posedge clk_i) begin
    span_result_t want;
    if (rst_ni) begin
      if (rsp.valid && rsp.ready) begin
        if (pending_spans.size() == 0) begin
          $error("response transfer with no request waiting");
          fail_count++;
        end else begin
          want = pending_spans.pop_front();
          if (rsp.span_row !== want.row) begin
            $error("span_row: expected %0d, got %0d", want.row, rsp.span_row);
            fail_count++;
          end
          if (rsp.span_left !== want.left) begin
            $error("span_left: expected %0d, got %0d", want.left, rsp.span_left);
            fail_count++;
          end
          if (rsp.span_right !== want.right) begin
            $error("span_right: expected %0d, got %0d", want.right, rsp.span_right);
            fail_count++;
          end
          if (rsp.span_fill !== want.fill) begin
            $error("span_fill: expected %0d, got %0d", want.fill, rsp.span_fill);
            fail_count++;
          end
        end
      end
      if (req.valid && req.ready) begin
        pending_spans.insert(pending_spans.size(),
                             predict_span(cpst_pkg::op_e'(req.opcode),
                                          longint'(req.first_x),
                                          longint'(req.first_y),
                                          longint'(req.second_x),
                                          longint'(req.second_y),
                                          req.row_index));
      end
      pending_count = pending_spans.size();
    end
  end

endmodule

// ===== test/tb.sv =====
// Drives requests into the span table with random gaps, stalls the response
// side at random, and reports the verdict from the checker's failure and pending counts.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;
  localparam int ITEM_TARGET = 580;

  logic clk_i;
  logic rst_ni;
  logic steady;
  int   sent_items;
  int   idle_cycles;
  int   fail_count;
  int   pending_count;

  cpst_in_if  req ();
  cpst_out_if rsp ();

  convex_polygon_span_table u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  span_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req           (req),
    .rsp           (rsp),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Send one request and return at the edge where it is transferred. The
  // coordinates keep their low 16 bits and the row its low 10 bits.
  task automatic issue(input cpst_pkg::op_e op,
                       input int ax, input int ay,
                       input int bx, input int by,
                       input int row);
    int gap;
    gap = idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      req.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req.opcode    = op;
    req.first_x   = 16'(ax);
    req.first_y   = 16'(ay);
    req.second_x  = 16'(bx);
    req.second_y  = 16'(by);
    req.row_index = 10'(row);
    req.valid     = 1'b1;
    do begin
      @(posedge clk_i);
    end while (!req.ready);
    sent_items++;
  endtask

  // Requests with every field drawn over its full range.
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) begin
      issue(cpst_pkg::op_e'($urandom_range(0, 3)), $urandom_range(0, 65535),
            $urandom_range(0, 65535), $urandom_range(0, 65535),
            $urandom_range(0, 65535), $urandom_range(0, 1023));
    end
  endtask

  // One polygon: usually a clear, its closed ring of edges, then row reads
  // mostly inside its vertical extent.
  task automatic draw_polygon();
    int n;
    int cx;
    int cy;
    int rad;
    int y_min;
    int y_max;
    int row;
    int m;
    int vx [6];
    int vy [6];
    if ($urandom_range(0, 4) != 0) begin
      issue(cpst_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
    n   = $urandom_range(3, 6);
    rad = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 600) : $urandom_range(1, 80);
    cx  = $urandom_range(0, 1200) - 100;
    cy  = $urandom_range(0, 1100) - 40;
    y_min = cy;
    y_max = cy;
    for (int k = 0; k < n; k++) begin
      vx[k] = cx + $urandom_range(0, 2 * rad) - rad;
      vy[k] = cy + $urandom_range(0, 2 * rad) - rad;
      if (vy[k] < y_min) y_min = vy[k];
      if (vy[k] > y_max) y_max = vy[k];
    end
    for (int k = 0; k < n; k++) begin
      issue(cpst_pkg::OP_ADD, vx[k], vy[k], vx[(k + 1) % n], vy[(k + 1) % n], $urandom);
    end
    m = $urandom_range(4, 12);
    repeat (m) begin
      if ($urandom_range(0, 4) == 0) begin
        row = $urandom_range(0, 1023);
      end else begin
        row = y_min - 1 + $urandom_range(0, y_max - y_min + 1);
      end
      if (row < 0) row = 0;
      if (row > 1023) row = 1023;
      issue(cpst_pkg::OP_READ, $urandom, $urandom, $urandom, $urandom, row);
    end
  endtask

  // Hold off on the response side at random.
  initial begin
    int n;
    rsp.ready = 1'b0;
    forever begin
      n = idle_len();
      @(negedge clk_i);
      if (n > 0) begin
        rsp.ready = 1'b0;
        repeat (n) @(negedge clk_i);
      end
      rsp.ready = 1'b1;
      repeat ($urandom_range(0, 8)) @(negedge clk_i);
    end
  end

  // Stop the run when no transfer happens for too long.
  initial idle_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    steady        = 1'b0;
    sent_items    = 0;
    req.valid     = 1'b0;
    req.opcode    = cpst_pkg::OP_NOP;
    req.first_x   = '0;
    req.first_y   = '0;
    req.second_x  = '0;
    req.second_y  = '0;
    req.row_index = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty table after reset, the unused opcode and a horizontal edge.
    issue(cpst_pkg::OP_READ, 0, 0, 0, 0, 0);
    issue(cpst_pkg::OP_READ, 0, 0, 0, 0, 1023);
    issue(cpst_pkg::OP_NOP, -1, -1, -1, -1, 1023);
    issue(cpst_pkg::OP_ADD, 5, 7, 300, 7, 0);
    issue(cpst_pkg::OP_READ, 0, 0, 0, 0, 7);
    // Extreme corners: the edge crosses every row of the table.
    issue(cpst_pkg::OP_ADD, -32768, -32768, 32767, 32767, 0);
    issue(cpst_pkg::OP_READ, 0, 0, 0, 0, 0);
    issue(cpst_pkg::OP_READ, 0, 0, 0, 0, 1023);
    issue(cpst_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
    issue(cpst_pkg::OP_READ, 0, 0, 0, 0, 512);
    // A single vertical edge leaves left equal to right; a second one opens it.
    issue(cpst_pkg::OP_ADD, 5, 10, 5, 20, 0);
    issue(cpst_pkg::OP_READ, 0, 0, 0, 0, 15);
    issue(cpst_pkg::OP_ADD, 9, 20, 9, 10, 0);
    issue(cpst_pkg::OP_READ, 0, 0, 0, 0, 15);
    // Edges wholly above or below the table, straddling it, and at its end.
    issue(cpst_pkg::OP_ADD, 0, -500, 100, -1, 0);
    issue(cpst_pkg::OP_ADD, 0, 1024, 50, 32767, 0);
    issue(cpst_pkg::OP_ADD, -40, -30, 900, 60, 0);
    issue(cpst_pkg::OP_ADD, 700, 1030, -200, 1000, 0);
    issue(cpst_pkg::OP_ADD, 100, 1000, 50, 1024, 0);
    issue(cpst_pkg::OP_READ, 0, 0, 0, 0, 1000);
    issue(cpst_pkg::OP_READ, 0, 0, 0, 0, 1023);
    issue(cpst_pkg::OP_READ, 0, 0, 0, 0, 0);
    // A steep slope: x spans the full field over three rows.
    issue(cpst_pkg::OP_ADD, 32767, 0, -32768, 3, 0);
    issue(cpst_pkg::OP_READ, 0, 0, 0, 0, 1);
    issue(cpst_pkg::OP_CLEAR, 0, 0, 0, 0, 0);

    // Random part: mostly polygons, with noise between them.
    while (sent_items < ITEM_TARGET) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) begin
        send_noise();
      end else begin
        draw_polygon();
      end
    end
    steady = 1'b0;
    @(negedge clk_i);
    req.valid = 1'b0;

    while (pending_count != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
